// ===== hdl/stbs_pkg.sv =====
// Sorted table binary search: shared types and constants.
// Item and result structs, action codes and controller states.
// No dependencies.
`timescale 1ns / 1ps

package stbs_pkg;

	localparam int KEY_W = 32;
	localparam int IDX_W = 10;
	localparam int CNT_W = 11;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SEARCH = 1'b1;

	typedef struct packed {
		logic                    action;
		logic [IDX_W-1:0]        load_index;
		logic signed [KEY_W-1:0] load_value;
		logic signed [KEY_W-1:0] search_key;
	} item_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] match_index;
	} result_t;

	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} state_t;

endpackage

// ===== hdl/sorted_table_binary_search.sv =====
// Sorted table binary search: top level with search controller.
// Holds the entry count register and walks the table one probe per cycle.
// Depends on stbs_pkg and stbs_table.
//
// Usage:
//   Items enter on request when start is high and busy is low. A load item
//   writes one table entry in that cycle and gives no result; busy stays low.
//   A search item raises busy while the table is probed, one memory read per
//   cycle, and gives one result on result, marked by done for one cycle.
//   A search makes P <= floor(log2(entries_in_use)) + 1 probes (at most 11
//   with 1024 entries); the next item may enter in the cycle done is shown.
//   The single memory read port limits the search to one probe a cycle.
//   An empty table gives its not-found result in the next cycle.
//   entries_in_use is written over cfg_valid/cfg_ready/cfg_data while idle;
//   a count above TABLE_DEPTH covers the whole table.
//   Reset clears the controller and the count; the table keeps no reset
//   value, so entries must be loaded before they are searched.
//   The receiver cannot stall: each result is valid for its one done cycle.
`timescale 1ns / 1ps

module sorted_table_binary_search #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  stbs_pkg::item_t             request,
	output logic                        done,
	output stbs_pkg::result_t           result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [stbs_pkg::CNT_W-1:0]  cfg_data
);
	import stbs_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = (CW > CNT_W) ? CW : CNT_W;

	state_t                  state_q, state_nx;
	logic [CNT_W-1:0]        entries_q;
	logic [CW-1:0]           cnt;
	logic [CW-1:0]           lo_q, hi_q, lo_n, hi_n;
	logic [AW-1:0]           mid_q, mid_nx;
	logic [CW:0]             sum;
	logic signed [KEY_W-1:0] key_q;
	logic signed [KEY_W-1:0] probe;
	logic                    key_lt, key_eq, more;
	logic                    accept, acc_search, acc_load, load_ok;
	logic                    ram_we, ram_re;
	logic                    done_q;
	result_t                 result_q;
	logic [31:0]             mid_w;

	assign accept     = start && !busy;
	assign acc_search = accept && (request.action == ACT_SEARCH);
	assign acc_load   = accept && (request.action == ACT_LOAD);
	assign load_ok    = {22'b0, request.load_index} < 32'(TABLE_DEPTH);

	assign cnt = (EW'(entries_q) > EW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(entries_q);

	stbs_table #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.AW         (AW)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(request.load_index)),
		.wdata(request.load_value),
		.re   (ram_re),
		.raddr(mid_nx),
		.rdata(probe)
	);

	always_comb begin
		key_lt = key_q < probe;
		key_eq = key_q == probe;
		lo_n   = key_lt ? lo_q : CW'(mid_q) + CW'(1);
		hi_n   = key_lt ? CW'(mid_q) : hi_q;
		more   = lo_n < hi_n;
		if (state_q == ST_IDLE) begin
			sum = {1'b0, cnt} - (CW+1)'(1);
		end else begin
			sum = {1'b0, lo_n} + {1'b0, hi_n} - (CW+1)'(1);
		end
		mid_nx = AW'(sum >> 1);
		mid_w  = 32'(mid_q);
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc_search && (cnt != '0)) begin
					state_nx = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (key_eq || !more) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		busy      = (state_q == ST_SEARCH);
		cfg_ready = !busy;
		ram_we    = acc_load && load_ok;
		ram_re    = (acc_search && (cnt != '0)) ||
		            ((state_q == ST_SEARCH) && !key_eq && more);
		done      = done_q;
		result    = result_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			entries_q <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= (acc_search && (cnt == '0)) ||
			           ((state_q == ST_SEARCH) && (key_eq || !more));
			if (cfg_valid && cfg_ready) begin
				entries_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_search) begin
			key_q <= request.search_key;
			lo_q  <= '0;
			hi_q  <= cnt;
			mid_q <= mid_nx;
			result_q.found       <= 1'b0;
			result_q.match_index <= '0;
		end else if (state_q == ST_SEARCH) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= mid_nx;
			result_q.found       <= key_eq;
			result_q.match_index <= key_eq ? mid_w[IDX_W-1:0] : '0;
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while search still running");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> ((lo_q <= CW'(mid_q)) && (CW'(mid_q) < hi_q)))
		else $error("probe outside the live range");

	a_hi_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (hi_q <= cnt))
		else $error("upper bound beyond entry count");

	a_found_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.found) |-> (32'(result.match_index) < 32'(cnt)))
		else $error("match index beyond entry count");

endmodule

// ===== hdl/stbs_table.sv =====
// Sorted table binary search: entry storage.
// Single-port-write, single-port-read synchronous memory, registered read data.
// Depends on stbs_pkg.
`timescale 1ns / 1ps

module stbs_table #(
	parameter int TABLE_DEPTH = 1024,
	parameter int AW          = 10
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [AW-1:0]                    waddr,
	input  logic signed [stbs_pkg::KEY_W-1:0] wdata,
	input  logic                             re,
	input  logic [AW-1:0]                    raddr,
	output logic signed [stbs_pkg::KEY_W-1:0] rdata
);
	import stbs_pkg::*;

	logic signed [KEY_W-1:0] mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== dv/testbench.sv =====
// Testbench for sorted_table_binary_search: directed and random load and search items,
// each search result checked against a shadow copy of the table and the entry count.
// Depends on stbs_pkg and the sorted_table_binary_search RTL.
`timescale 1ns / 1ps

module testbench;
	import stbs_pkg::*;

	localparam int DEPTH = 1024;
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_ITEMS = 360;
	localparam int CYCLE_LIMIT = 500000;
	localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	item_t              request;
	logic               done;
	result_t            result;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CNT_W-1:0]   cfg_data;

	logic signed [KEY_W-1:0] entry_shadow [DEPTH];
	logic [CNT_W-1:0]        count_shadow;
	result_t                 pending_outcomes [$];
	result_t                 oldest_outcome;

	int error_count = 0;
	int load_count = 0;
	int search_count = 0;
	int hit_count = 0;
	int config_count = 0;
	int random_items = 0;
	int idle_free_left = 0;
	int cycle_count = 0;

	sorted_table_binary_search #(.TABLE_DEPTH(DEPTH)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic result_t search_outcome(input logic signed [KEY_W-1:0] key);
		result_t r;
		int lo, hi, mid, n;
		r = '0;
		n = (count_shadow > DEPTH) ? DEPTH : int'(count_shadow);
		lo = 0;
		hi = n - 1;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (key < entry_shadow[mid]) begin
				hi = mid - 1;
			end else if (key > entry_shadow[mid]) begin
				lo = mid + 1;
			end else begin
				r.found = 1'b1;
				r.match_index = IDX_W'(mid);
				break;
			end
		end
		return r;
	endfunction

	task automatic send_item(input item_t it);
		int gap;
		if (idle_free_left > 0) begin
			idle_free_left--;
			gap = 0;
		end else begin
			if ($urandom_range(0, 15) == 0)
				idle_free_left = $urandom_range(8, 40);
			gap = $urandom_range(0, 7);
		end
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		request <= it;
		do
			@(posedge clk);
		while (busy);
		if (it.action == ACT_LOAD) begin
			entry_shadow[it.load_index] = it.load_value;
			load_count++;
		end else begin
			pending_outcomes.push_back(search_outcome(it.search_key));
			search_count++;
		end
	endtask

	task automatic load_entry(input int idx, input logic signed [KEY_W-1:0] value);
		item_t it;
		it.action = ACT_LOAD;
		it.load_index = IDX_W'(idx);
		it.load_value = value;
		it.search_key = $urandom;
		send_item(it);
	endtask

	task automatic search_for(input logic signed [KEY_W-1:0] key);
		item_t it;
		it.action = ACT_SEARCH;
		it.load_index = IDX_W'($urandom);
		it.load_value = $urandom;
		it.search_key = key;
		send_item(it);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_count(input logic [CNT_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		count_shadow = value;
		config_count++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// keep the prefix at or below the entry that follows it
	task automatic fill_sorted(input int n, input bit dense);
		longint upper, step, v;
		int i;
		upper = (n < DEPTH) ? longint'(entry_shadow[n]) : longint'(KEY_MAX);
		if (dense) begin
			step = 4;
			v = upper - 4 * n;
		end else begin
			step = (upper - longint'(KEY_MIN) + 1) / n;
			v = longint'(KEY_MIN);
		end
		if (step < 1)
			step = 1;
		if (v < longint'(KEY_MIN))
			v = longint'(KEY_MIN);
		for (i = 0; i < n; i++) begin
			v += longint'($urandom_range(0, 32'(step - 1)));
			if (v > upper)
				v = upper;
			load_entry(i, KEY_W'(v));
		end
	endtask

	task automatic small_table_test();
		search_for(32'sd0);
		search_for(KEY_MIN);
		write_count('0);
		search_for(KEY_MAX);
		load_entry(0, KEY_MIN);
		load_entry(1, -32'sd5);
		load_entry(2, 32'sd0);
		load_entry(3, 32'sd7);
		load_entry(4, KEY_MAX);
		write_count(CNT_W'(5));
		search_for(KEY_MIN);
		search_for(-32'sd5);
		search_for(32'sd0);
		search_for(32'sd7);
		search_for(KEY_MAX);
		search_for(32'sd6);
		search_for(KEY_MIN + 32'sd1);
		search_for(KEY_MAX - 32'sd1);
		// break the order: key sits off the probe path
		load_entry(4, -32'sd100);
		search_for(-32'sd100);
		load_entry(4, KEY_MAX);
		write_count(CNT_W'(1));
		search_for(KEY_MIN);
		search_for(-32'sd5);
	endtask

	task automatic full_table_test();
		fill_sorted(DEPTH, 1'b0);
		load_entry(0, KEY_MIN);
		load_entry(DEPTH - 1, KEY_MAX);
		write_count(CNT_W'(DEPTH));
		search_for(KEY_MIN);
		search_for(KEY_MAX);
		search_for(entry_shadow[511]);
		search_for(entry_shadow[1022]);
		search_for($urandom);
		write_count('1);
		search_for(KEY_MAX);
		search_for(entry_shadow[700]);
		write_count(CNT_W'(DEPTH + 1));
		search_for(KEY_MIN);
		search_for(entry_shadow[3]);
	endtask

	task automatic random_phases_test();
		int n, phase_len, pick, idx;
		logic [CNT_W-1:0] count_value;
		logic signed [KEY_W-1:0] key;
		longint lo_v, hi_v;
		while (random_items < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				count_value = '0;
			else if (pick == 1)
				count_value = CNT_W'(DEPTH);
			else if (pick == 2)
				count_value = '1;
			else if (pick == 3)
				count_value = CNT_W'($urandom_range(DEPTH + 1, 2047));
			else if (pick < 7)
				count_value = CNT_W'($urandom_range(33, DEPTH - 1));
			else
				count_value = CNT_W'($urandom_range(1, 32));
			n = (count_value > DEPTH) ? DEPTH : int'(count_value);
			if (n > 0 && n <= 32 && $urandom_range(0, 3) != 0)
				fill_sorted(n, $urandom_range(0, 2) == 0);
			write_count(count_value);
			phase_len = $urandom_range(10, 50);
			repeat (phase_len) begin
				pick = $urandom_range(0, 99);
				if (pick < 80) begin
					if (n == 0 || pick >= 70)
						key = $urandom;
					else if (pick >= 60)
						key = entry_shadow[$urandom_range(0, n - 1)]
							+ ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
					else
						key = entry_shadow[$urandom_range(0, n - 1)];
					search_for(key);
				end else if (pick < 95 && n > 0) begin
					idx = $urandom_range(0, n - 1);
					lo_v = (idx > 0) ? longint'(entry_shadow[idx - 1]) : longint'(KEY_MIN);
					hi_v = (idx < n - 1) ? longint'(entry_shadow[idx + 1]) : longint'(KEY_MAX);
					if (hi_v < lo_v)
						hi_v = lo_v;
					load_entry(idx, KEY_W'(lo_v + longint'({$urandom, $urandom}
						% (hi_v - lo_v + 1))));
				end else begin
					load_entry($urandom_range(0, DEPTH - 1), $urandom);
				end
				random_items++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				$error("result with no search outstanding: found %0b, match_index %0d",
					result.found, result.match_index);
				error_count++;
			end else begin
				oldest_outcome = pending_outcomes.pop_front();
				if (oldest_outcome.found)
					hit_count++;
				if (result.found !== oldest_outcome.found) begin
					$error("found: expected %0b, actual %0b", oldest_outcome.found,
						result.found);
					error_count++;
				end
				if (result.match_index !== oldest_outcome.match_index) begin
					$error("match_index: expected %0d, actual %0d",
						oldest_outcome.match_index, result.match_index);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin : run
		int i;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		count_shadow = '0;
		for (i = 0; i < DEPTH; i++)
			entry_shadow[i] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		small_table_test();
		full_table_test();
		random_phases_test();
		wait_idle();
		$display("Covered %0d loads and %0d searches (%0d hits) over %0d count settings,",
			load_count, search_count, hit_count, config_count);
		$display("including empty, full, oversized and unsorted tables, in %0d cycles.",
			cycle_count);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/stbs_pkg.sv
hdl/stbs_table.sv
hdl/sorted_table_binary_search.sv
dv/testbench.sv
